FILE: rtl/core/tga_truecolor_stream_parser_unit_defines.svh
// assertion macros shared by the parser modules
`ifndef TGA_TRUECOLOR_STREAM_PARSER_UNIT_DEFINES_SVH
`define TGA_TRUECOLOR_STREAM_PARSER_UNIT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define TGA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define TGA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/tga_pkg.sv
package tga_pkg;

    // header layout
    localparam logic [4:0] HDR_LAST_IDX    = 5'd17;
    localparam logic [4:0] HDR_IDX_CMAP    = 5'd1;
    localparam logic [4:0] HDR_IDX_TYPE    = 5'd2;
    localparam logic [4:0] HDR_IDX_WIDTH_L = 5'd12;
    localparam logic [4:0] HDR_IDX_WIDTH_H = 5'd13;
    localparam logic [4:0] HDR_IDX_HEIGHT_L = 5'd14;
    localparam logic [4:0] HDR_IDX_HEIGHT_H = 5'd15;
    localparam logic [4:0] HDR_IDX_DEPTH   = 5'd16;
    localparam logic [4:0] HDR_IDX_IDLEN   = 5'd0;
    localparam logic [7:0] TYPE_TRUECOLOR  = 8'd2;

    // final status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_SHORT     = 3'd1;
    localparam logic [2:0] ST_BAD_FIELD = 3'd2;
    localparam logic [2:0] ST_ZERO_DIM  = 3'd3;
    localparam logic [2:0] ST_TRUNC     = 3'd4;

    // command queue between front and back
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;
    localparam int FIFO_CW    = 3;

    // pixel byte counter width
    localparam int PIX_CW = 38;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_file;
    } in_t;

    typedef struct packed {
        logic        pixel_valid;
        logic [7:0]  pixel_byte;
        logic        done_res;
        logic [2:0]  status;
        logic [15:0] image_width;
        logic [15:0] image_height;
        logic [7:0]  bits_per_pixel;
    } out_t;

    // classified request handed from front to back
    typedef struct packed {
        logic        pix;
        logic        done;
        logic        dims_ok;
        logic [7:0]  data_byte;
        logic [2:0]  status;
        logic [15:0] width;
        logic [15:0] height;
        logic [7:0]  depth;
    } cmd_t;

    // queue status seen by both ends
    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

endpackage

FILE: rtl/core/tga_truecolor_stream_parser_unit.sv
// channel   | ports                    | request taken when
// ----------+--------------------------+---------------------------
// input     | push, full, item         | push && !full
// result    | empty, pop, result       | pop && !empty
//
// one file byte per cycle is taken while full is low; a pixel byte or the
// last byte goes into the queue, then into the result register when that is free
// the pixel byte total comes from two registered multiplies during the last
// header bytes, so the header does not stall the input
// full rises only while the four-entry queue is full behind an unpopped result
// reset is asynchronous and active low; the last byte of a file restarts the parser
module tga_truecolor_stream_parser_unit (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    output logic          full,
    input  tga_pkg::in_t  item,
    output logic          empty,
    input  logic          pop,
    output tga_pkg::out_t result
);
    import tga_pkg::*;

    logic       wr_en;
    logic       rd_en;
    cmd_t       wr_cmd;
    cmd_t       rd_cmd;
    fifo_stat_t stat;

    assign full = stat.full;

    // byte parser and classifier
    tga_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (stat.full),
        .item  (item),
        .wr_en (wr_en),
        .cmd   (wr_cmd)
    );

    // request queue
    tga_cmd_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_data (wr_cmd),
        .rd_en   (rd_en),
        .rd_data (rd_cmd),
        .stat    (stat)
    );

    // result formatting and output register
    tga_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .stat   (stat),
        .cmd    (rd_cmd),
        .rd_en  (rd_en),
        .pop    (pop),
        .empty  (empty),
        .result (result)
    );

endmodule

FILE: rtl/core/tga_front.sv
`include "tga_truecolor_stream_parser_unit_defines.svh"

module tga_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  logic          full,
    input  tga_pkg::in_t  item,
    output logic          wr_en,
    output tga_pkg::cmd_t cmd
);
    import tga_pkg::*;

    typedef enum logic [3:0] {
        PH_HEADER = 4'b0001,
        PH_SKIP   = 4'b0010,
        PH_PIXELS = 4'b0100,
        PH_IGNORE = 4'b1000
    } phase_t;

    phase_t              phase_reg, phase_next;
    logic [4:0]          hdr_idx_reg, hdr_idx_next;
    logic [7:0]          id_len_reg, id_len_next;
    logic [7:0]          skip_reg, skip_next;
    logic [15:0]         width_reg, width_next;
    logic [15:0]         height_reg, height_next;
    logic [7:0]          depth_reg, depth_next;
    logic                bad_reg, bad_next;
    logic [PIX_CW-1:0]   count_reg, count_next;
    logic [31:0]         wh_reg;
    logic [PIX_CW-1:0]   prod_reg;
    logic                accept;
    logic                pix;
    logic                last;
    logic [7:0]          b;
    logic                dims_zero;
    phase_t              after_id;
    logic [2:0]          status;
    logic                restarted;

    assign accept = push && !full;
    assign b      = item.data_byte;
    assign last   = item.end_of_file;

    // pixel byte total, settles during the last header bytes
    always_ff @(posedge clk)
    begin
        wh_reg   <= width_reg * height_reg;
        prod_reg <= {6'd0, wh_reg} * {33'd0, depth_reg[7:3]};
    end

    // parser next state
    always_comb
    begin
        phase_next   = phase_reg;
        hdr_idx_next = hdr_idx_reg;
        id_len_next  = id_len_reg;
        skip_next    = skip_reg;
        width_next   = width_reg;
        height_next  = height_reg;
        depth_next   = depth_reg;
        bad_next     = bad_reg;
        count_next   = count_reg;
        pix          = 1'b0;
        after_id     = PH_IGNORE;

        unique case (phase_reg)
            PH_HEADER:
            begin
                case (hdr_idx_reg)
                    HDR_IDX_IDLEN:    id_len_next = b;
                    HDR_IDX_CMAP:     if (b != 8'd0) bad_next = 1'b1;
                    HDR_IDX_TYPE:     if (b != TYPE_TRUECOLOR) bad_next = 1'b1;
                    HDR_IDX_WIDTH_L:  width_next[7:0] = b;
                    HDR_IDX_WIDTH_H:  width_next[15:8] = b;
                    HDR_IDX_HEIGHT_L: height_next[7:0] = b;
                    HDR_IDX_HEIGHT_H: height_next[15:8] = b;
                    HDR_IDX_DEPTH:
                    begin
                        depth_next = b;
                        if (b == 8'd0 || b[2:0] != 3'd0)
                            bad_next = 1'b1;
                    end
                    default: ;
                endcase
                hdr_idx_next = hdr_idx_reg + 5'd1;
                if (hdr_idx_reg == HDR_LAST_IDX)
                begin
                    // good header with nonzero dims always has pixel bytes
                    if (bad_next || width_reg == 16'd0 || height_reg == 16'd0)
                        after_id = PH_IGNORE;
                    else
                        after_id = PH_PIXELS;
                    if (id_len_reg != 8'd0)
                    begin
                        skip_next  = id_len_reg;
                        phase_next = PH_SKIP;
                    end
                    else
                    begin
                        phase_next = after_id;
                    end
                end
            end
            PH_SKIP:
            begin
                skip_next = skip_reg - 8'd1;
                if (bad_reg || width_reg == 16'd0 || height_reg == 16'd0)
                    after_id = PH_IGNORE;
                else
                    after_id = PH_PIXELS;
                if (skip_next == 8'd0)
                    phase_next = after_id;
            end
            PH_PIXELS:
            begin
                pix        = 1'b1;
                count_next = count_reg + PIX_CW'(1);
                if (count_next == prod_reg)
                    phase_next = PH_IGNORE;
            end
            PH_IGNORE: ;
            default:   phase_next = PH_HEADER;
        endcase
    end

    // final status, in precedence order
    assign dims_zero = (width_next == 16'd0) || (height_next == 16'd0);

    always_comb
    begin
        if (phase_next == PH_HEADER)
            status = ST_SHORT;
        else if (bad_next)
            status = ST_BAD_FIELD;
        else if (dims_zero)
            status = ST_ZERO_DIM;
        else if (phase_next == PH_SKIP || phase_next == PH_PIXELS)
            status = ST_TRUNC;
        else
            status = ST_OK;
    end

    // request toward the queue
    assign wr_en         = accept && (pix || last);
    assign cmd.pix       = pix;
    assign cmd.done      = last;
    assign cmd.dims_ok   = (phase_next != PH_HEADER);
    assign cmd.data_byte = b;
    assign cmd.status    = status;
    assign cmd.width     = width_next;
    assign cmd.height    = height_next;
    assign cmd.depth     = depth_next;

    // parser state, cleared again after the last byte of a file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HEADER;
            hdr_idx_reg <= '0;
            id_len_reg  <= '0;
            skip_reg    <= '0;
            width_reg   <= '0;
            height_reg  <= '0;
            depth_reg   <= '0;
            bad_reg     <= 1'b0;
            count_reg   <= '0;
        end
        else if (accept)
        begin
            if (last)
            begin
                phase_reg   <= PH_HEADER;
                hdr_idx_reg <= '0;
                id_len_reg  <= '0;
                skip_reg    <= '0;
                width_reg   <= '0;
                height_reg  <= '0;
                depth_reg   <= '0;
                bad_reg     <= 1'b0;
                count_reg   <= '0;
            end
            else
            begin
                phase_reg   <= phase_next;
                hdr_idx_reg <= hdr_idx_next;
                id_len_reg  <= id_len_next;
                skip_reg    <= skip_next;
                width_reg   <= width_next;
                height_reg  <= height_next;
                depth_reg   <= depth_next;
                bad_reg     <= bad_next;
                count_reg   <= count_next;
            end
        end
    end

    // parser sits at the first header byte
    assign restarted = (phase_reg == PH_HEADER) && (hdr_idx_reg == 5'd0);

    // checks
    `TGA_ASSERT_NEXT(a_eof_restart, accept && last, restarted, "parser did not restart")
    `TGA_ASSERT_NOW(a_pix_range, phase_reg == PH_PIXELS, count_reg < prod_reg, "count past size")

endmodule

FILE: rtl/core/tga_cmd_fifo.sv
`include "tga_truecolor_stream_parser_unit_defines.svh"

module tga_cmd_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  tga_pkg::cmd_t       wr_data,
    input  logic                rd_en,
    output tga_pkg::cmd_t       rd_data,
    output tga_pkg::fifo_stat_t stat
);
    import tga_pkg::*;

    cmd_t               mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg;
    logic [FIFO_AW-1:0] rd_ptr_reg;
    logic [FIFO_CW-1:0] count_reg;
    logic [FIFO_CW-1:0] cnt_inc;
    logic [FIFO_CW-1:0] cnt_dec;
    logic               do_wr;
    logic               do_rd;

    assign stat.full  = (count_reg == FIFO_CW'(FIFO_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_wr      = wr_en && !stat.full;
    assign do_rd      = rd_en && !stat.empty;
    assign rd_data    = mem_reg[rd_ptr_reg];
    assign cnt_inc    = count_reg + FIFO_CW'(1);
    assign cnt_dec    = count_reg - FIFO_CW'(1);

    // storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(1);
            if (do_rd)
                rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(1);
            if (do_wr && !do_rd)
                count_reg <= cnt_inc;
            else if (do_rd && !do_wr)
                count_reg <= cnt_dec;
        end
    end

    // checks
    `TGA_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= FIFO_CW'(FIFO_DEPTH), "queue overfilled")
    `TGA_ASSERT_NEXT(a_count_up, do_wr && !do_rd, count_reg == $past(cnt_inc), "missed write")
    `TGA_ASSERT_NEXT(a_count_down, do_rd && !do_wr, count_reg == $past(cnt_dec), "missed read")

endmodule

FILE: rtl/core/tga_back.sv
module tga_back (
    input  logic                clk,
    input  logic                rst_n,
    input  tga_pkg::fifo_stat_t stat,
    input  tga_pkg::cmd_t       cmd,
    output logic                rd_en,
    input  logic                pop,
    output logic                empty,
    output tga_pkg::out_t       result
);
    import tga_pkg::*;

    logic valid_reg;
    out_t data_reg, data_next;

    // refill the result register when it is free or being taken
    assign rd_en  = !stat.empty && (!valid_reg || pop);
    assign empty  = !valid_reg;
    assign result = data_reg;

    // format a request into a result, zeroing fields that do not apply
    always_comb
    begin
        data_next.pixel_valid    = cmd.pix;
        data_next.pixel_byte     = cmd.pix ? cmd.data_byte : 8'd0;
        data_next.done_res       = cmd.done;
        data_next.status         = cmd.done ? cmd.status : ST_OK;
        data_next.image_width    = (cmd.done && cmd.dims_ok) ? cmd.width : 16'd0;
        data_next.image_height   = (cmd.done && cmd.dims_ok) ? cmd.height : 16'd0;
        data_next.bits_per_pixel = (cmd.done && cmd.dims_ok) ? cmd.depth : 8'd0;
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (rd_en)
            data_reg <= data_next;
    end

    // result occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (rd_en)
            valid_reg <= 1'b1;
        else if (pop)
            valid_reg <= 1'b0;
    end

endmodule
